/* rtl/vdi_pkg.sv */
// Shared types and fixed field widths for the vertex deduplication indexer.
// Depends on nothing; used by the controller, the datapath and the top level.
package vdi_pkg;

  localparam int COORD_W = 32;
  localparam int VIDX_W  = 6;
  localparam int UCNT_W  = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic take_hit;
    logic take_miss;
    logic emit;
  } vdi_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_more;
    logic hit;
    logic scan_over;
    logic out_free;
  } vdi_stat_t;

endpackage

/* rtl/vertex_dedup_indexer.sv */
// Top level of the vertex deduplication indexer.
// Depends on vdi_pkg, vdi_ctrl and vdi_dpath.
//
// The block takes one vertex request at a time (three 32-bit float bit
// patterns) and looks it up in a table of the distinct vertices seen so far
// in the current mesh. Coordinates are compared as raw bits, so +0 and -0
// are different vertices and identical NaN patterns match. On a match the
// result carries the index of the first matching entry; otherwise the vertex
// is appended and the result carries its new index with is_new set. When the
// table already holds TABLE_DEPTH entries and nothing matches, nothing is
// stored, the index reads TABLE_DEPTH-1 and overflow is set. Every result
// also carries the number of distinct vertices stored after the request.
// A request marked with tlast ends the mesh: its result goes out with tlast
// set and the table is emptied afterwards. The table is searched one entry
// per clock through the single read port of the table memory, from entry 0
// up. The search stops at the first match; a request that misses reads every
// stored entry. No new request is taken until the last one has been searched
// and its result moved into the output register.
// Results wait in an output register, so a stalled output side holds up
// only the next result, not the next search. The table needs no clearing
// pass after reset: only entries below the running count are ever read.
module vertex_dedup_indexer #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata, from bit 0 up: vertex_x[31:0], vertex_y[31:0], vertex_z[31:0]
  input  logic [95:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tlast,
  // m_tdata, from bit 0 up: vertex_index[5:0], is_new, unique_count[6:0],
  // overflow, one zero pad bit
  output logic [15:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic        m_tlast
);

  vdi_pkg::vdi_cmd_t  cmd;
  vdi_pkg::vdi_stat_t stat;

  // The controller sequences accept, scan, append and result hand-off.
  vdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath owns the table memory, the entry count and the result register.
  vdi_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .key_in    (s_tdata),
    .last_in   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* rtl/vdi_ctrl.sv */
// Controller state machine of the vertex deduplication indexer.
// Depends on vdi_pkg for the command and status structs.
module vdi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vdi_pkg::vdi_stat_t stat,
  output vdi_pkg::vdi_cmd_t  cmd
);

  typedef enum logic [1:0] {IDLE, SCAN, MISS, OUT} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = SCAN;
        end
      end
      SCAN: begin
        cmd.issue = stat.scan_more && !stat.hit;
        if (stat.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = OUT;
        end else if (stat.scan_over) begin
          state_next = MISS;
        end
      end
      MISS: begin
        cmd.take_miss = 1'b1;
        state_next    = OUT;
      end
      OUT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/vdi_dpath.sv */
// Datapath of the vertex deduplication indexer: vertex table memory, search
// pointer, compare stage, entry count and the result register.
// Depends on vdi_pkg for field widths and the command and status structs.
module vdi_dpath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vdi_pkg::vdi_cmd_t             cmd,
  output vdi_pkg::vdi_stat_t            stat,
  input  logic [3*vdi_pkg::COORD_W-1:0] key_in,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_data,
  output logic                          out_last
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = 3 * vdi_pkg::COORD_W;

  logic [KW-1:0] mem [TABLE_DEPTH];

  logic [KW-1:0] key;
  logic          last_r;
  logic [CW-1:0] ptr;
  logic [KW-1:0] rd_data;
  logic          cmp_valid;
  logic [IW-1:0] cmp_idx;
  logic [CW-1:0] count;
  logic [IW-1:0] res_idx;
  logic          res_new;
  logic          res_ovf;
  logic          full;

  logic [CW+vdi_pkg::UCNT_W-1:0] count_ext;
  logic [IW+vdi_pkg::VIDX_W-1:0] idx_ext;

  assign full           = (count == CW'(TABLE_DEPTH));
  assign stat.scan_more = (ptr != count);
  assign stat.hit       = cmp_valid && (rd_data == key);
  assign stat.scan_over = (ptr == count) && !cmp_valid;
  assign stat.out_free  = !out_valid || out_ready;

  assign count_ext = {{vdi_pkg::UCNT_W{1'b0}}, count};
  assign idx_ext   = {{vdi_pkg::VIDX_W{1'b0}}, res_idx};

  // Table memory: one write port for appends, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.take_miss && !full) begin
      mem[count[IW-1:0]] <= key;
    end
    if (cmd.issue) begin
      rd_data <= mem[ptr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key    <= key_in;
      last_r <= last_in;
    end
    if (cmd.issue) begin
      cmp_idx <= ptr[IW-1:0];
    end
    if (cmd.take_hit) begin
      res_idx <= cmp_idx;
      res_new <= 1'b0;
      res_ovf <= 1'b0;
    end else if (cmd.take_miss) begin
      if (full) begin
        res_idx <= IW'(TABLE_DEPTH - 1);
        res_new <= 1'b0;
        res_ovf <= 1'b1;
      end else begin
        res_idx <= count[IW-1:0];
        res_new <= 1'b1;
        res_ovf <= 1'b0;
      end
    end
    if (cmd.emit) begin
      out_data <= {1'b0, res_ovf, count_ext[vdi_pkg::UCNT_W-1:0], res_new,
                   idx_ext[vdi_pkg::VIDX_W-1:0]};
      out_last <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      cmp_valid <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr       <= '0;
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= cmd.issue;
        if (cmd.issue) begin
          ptr <= ptr + CW'(1);
        end
      end
      if (cmd.take_miss && !full) begin
        count <= count + CW'(1);
      end else if (cmd.emit && last_r) begin
        count <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
